// File: rtl/plt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the power lease table.
package plt_pkg;

  localparam int CAPACITY_DEF  = 8;
  localparam int SLOT_BITS_DEF = 3;
  localparam int DOMAINS_DEF   = 5;

  localparam int HANDLE_W  = 16;
  localparam int MASK_W    = 5;
  localparam int TIME_W    = 32;
  localparam int QDOM_W    = 3;
  localparam int OUT_CNT_W = 4;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NONE    = 2'd3
  } plt_op_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_NO_DOMAINS = 2'd1,
    ERR_EXHAUSTED  = 2'd2,
    ERR_NOT_HELD   = 2'd3
  } plt_err_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } plt_state_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [MASK_W-1:0]   domain_mask;
    logic [TIME_W-1:0]   deadline_ms;
    logic [HANDLE_W-1:0] handle_in;
    logic [TIME_W-1:0]   now_ms;
    logic [QDOM_W-1:0]   query_domain;
  } plt_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle_out;
    logic [1:0]           error_code;
    logic                 accepted;
    logic [MASK_W-1:0]    held_mask;
    logic [MASK_W-1:0]    overdue_mask;
    logic [OUT_CNT_W-1:0] holder_count;
    logic [OUT_CNT_W-1:0] outstanding_count;
  } plt_out_t;

  // Command broadcast to every slot cell.
  typedef struct packed {
    logic                acquire;
    logic                retire;
    logic [MASK_W-1:0]   dmask;
    logic [TIME_W-1:0]   deadline;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   now;
  } plt_cmd_t;

  // Data handed from one slot cell to the next one up the row.
  typedef struct packed {
    logic                found;     // a lower slot is free
    logic                hit;       // some cell took the acquire or release
    logic [HANDLE_W-1:0] handle;    // handle of the new lease
    logic [MASK_W-1:0]   rel_doms;  // domains of the released lease
    logic [MASK_W-1:0]   overdue;   // overdue domains so far
  } plt_link_t;

endpackage

// File: rtl/plt_cell.sv
`timescale 1ns / 1ps
// One lease slot of the table: generation, domains and deadline.
module plt_cell #(
  parameter int SLOT_BITS = plt_pkg::SLOT_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                commit,
  input  plt_pkg::plt_cmd_t   cmd,
  input  plt_pkg::plt_link_t  link_in,
  output plt_pkg::plt_link_t  link_out,
  output logic                act
);

  localparam int GEN_W = plt_pkg::HANDLE_W - SLOT_BITS;

  logic [GEN_W-1:0]              live_gen_r, live_gen_nxt;
  logic [GEN_W-1:0]              last_gen_r, last_gen_nxt;
  logic [plt_pkg::MASK_W-1:0]    dom_r, dom_nxt;
  logic [plt_pkg::TIME_W-1:0]    dl_r, dl_nxt;

  logic                          is_free;
  logic                          pick;
  logic                          release_hit;
  logic [GEN_W-1:0]              rel_gen;
  logic [SLOT_BITS-1:0]          rel_slot;
  logic [GEN_W-1:0]              gen_inc;
  logic [plt_pkg::MASK_W-1:0]    overdue;

  always_comb begin
    is_free  = (live_gen_r == '0);
    pick     = cmd.acquire && !link_in.found && is_free;
    rel_gen  = cmd.handle[plt_pkg::HANDLE_W-1:SLOT_BITS];
    rel_slot = cmd.handle[SLOT_BITS-1:0];
    release_hit = cmd.retire && (rel_slot == SLOT_BITS'(IDX)) &&
                  (rel_gen != '0) && (live_gen_r == rel_gen);
    // skip generation 0 on wrap
    gen_inc = (last_gen_r == '1) ? GEN_W'(1) : last_gen_r + GEN_W'(1);

    live_gen_nxt = live_gen_r;
    last_gen_nxt = last_gen_r;
    dom_nxt      = dom_r;
    dl_nxt       = dl_r;
    if (pick) begin
      live_gen_nxt = gen_inc;
      last_gen_nxt = gen_inc;
      dom_nxt      = cmd.dmask;
      dl_nxt       = cmd.deadline;
    end else if (release_hit) begin
      live_gen_nxt = '0;
    end

    overdue = ((live_gen_nxt != '0) && (dl_nxt != '0) && (cmd.now > dl_nxt)) ?
              dom_nxt : '0;

    link_out.found    = link_in.found | is_free;
    link_out.hit      = link_in.hit | pick | release_hit;
    link_out.handle   = link_in.handle | (pick ? {gen_inc, SLOT_BITS'(IDX)} : '0);
    link_out.rel_doms = link_in.rel_doms | (release_hit ? dom_r : '0);
    link_out.overdue  = link_in.overdue | overdue;
    act               = pick | release_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_gen_r <= '0;
      last_gen_r <= '0;
    end else if (commit) begin
      live_gen_r <= live_gen_nxt;
      last_gen_r <= last_gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      dom_r <= dom_nxt;
      dl_r  <= dl_nxt;
    end
  end

endmodule

// File: rtl/plt_holders.sv
`timescale 1ns / 1ps
// Per-domain holder counters with held mask and queried count.
module plt_holders #(
  parameter int HOLDERS = plt_pkg::MASK_W,
  parameter int CNT_W   = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          commit,
  input  logic [plt_pkg::MASK_W-1:0]    inc_mask,
  input  logic [plt_pkg::MASK_W-1:0]    dec_mask,
  input  logic [plt_pkg::QDOM_W-1:0]    qdom,
  output logic [plt_pkg::MASK_W-1:0]    held_nxt,
  output logic [CNT_W-1:0]              count_nxt
);

  logic [CNT_W-1:0] cnt_r   [HOLDERS];
  logic [CNT_W-1:0] cnt_nxt [HOLDERS];

  always_comb begin
    held_nxt  = '0;
    count_nxt = '0;
    for (int d = 0; d < HOLDERS; d++) begin
      cnt_nxt[d] = cnt_r[d];
      if (inc_mask[d]) begin
        cnt_nxt[d] = cnt_r[d] + CNT_W'(1);
      end else if (dec_mask[d] && (cnt_r[d] != '0)) begin
        // floor at zero
        cnt_nxt[d] = cnt_r[d] - CNT_W'(1);
      end
      held_nxt[d] = (cnt_nxt[d] != '0);
      if (qdom == plt_pkg::QDOM_W'(d)) begin
        count_nxt = cnt_nxt[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < HOLDERS; d++) begin
        cnt_r[d] <= '0;
      end
    end else if (commit) begin
      for (int d = 0; d < HOLDERS; d++) begin
        cnt_r[d] <= cnt_nxt[d];
      end
    end
  end

endmodule

// File: rtl/power_lease_table_core.sv
`timescale 1ns / 1ps
// Top level of the power lease table: slot cell row, holder counters, control.
//
// Usage
//   in_valid/in_stall/in_data carry one request beat (acquire, release or
//   query). out_valid/out_stall/out_data carry exactly one result beat per
//   request, in request order. A beat moves at a rising edge with valid high
//   and stall low.
//   A request is captured at one edge; at a later edge with the output free
//   it is committed to the slot cells and its result loaded into the output
//   register. No new request is taken while one is held: in_stall stays high
//   from capture until commit.
//   The slot row is a chain of CAPACITY cells; the lowest free slot, the
//   released lease's domains and the overdue mask ripple up the row, and each
//   cell updates its own generation, domains and deadline at the commit edge.
//   While the result register holds an untaken beat and out_stall is high, the
//   pending request waits and in_stall stays high; no beat is dropped.
//   Reset (rst_n low, synchronous) frees every slot, clears all generations,
//   holder counts and the lease count, and empties the output register.
module power_lease_table_core #(
  parameter int CAPACITY  = plt_pkg::CAPACITY_DEF,
  parameter int SLOT_BITS = plt_pkg::SLOT_BITS_DEF,
  parameter int DOMAINS   = plt_pkg::DOMAINS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  plt_pkg::plt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output plt_pkg::plt_out_t out_data
);

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int HOLDERS = (DOMAINS < plt_pkg::MASK_W) ? DOMAINS : plt_pkg::MASK_W;
  localparam logic [plt_pkg::MASK_W-1:0] DOM_VALID =
    (DOMAINS >= plt_pkg::MASK_W) ? '1 : plt_pkg::MASK_W'((1 << HOLDERS) - 1);

  plt_pkg::plt_state_t state_r, state_nxt;
  plt_pkg::plt_in_t    item_r;
  plt_pkg::plt_out_t   out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;

  logic                out_free;
  logic                commit;
  logic                in_take;
  plt_pkg::plt_cmd_t   cmd;
  plt_pkg::plt_link_t  link [CAPACITY+1];
  logic [CAPACITY-1:0] cell_act;
  logic [plt_pkg::MASK_W-1:0] dmask_m;
  logic [plt_pkg::MASK_W-1:0] inc_mask;
  logic [plt_pkg::MASK_W-1:0] held_nxt;
  logic [CNT_W-1:0]    count_nxt;
  logic                acq_ok;
  logic                rel_ok;
  logic [1:0]          err;

  assign out_free = !out_valid_r || !out_stall;
  assign in_take  = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = plt_pkg::ST_EXEC;
      end
      plt_pkg::ST_EXEC: begin
        if (out_free) state_nxt = plt_pkg::ST_IDLE;
      end
      default: state_nxt = plt_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    commit   = 1'b0;
    case (state_r)
      plt_pkg::ST_IDLE: in_stall = 1'b0;
      plt_pkg::ST_EXEC: commit   = out_free;
      default: begin
        in_stall = 1'b1;
        commit   = 1'b0;
      end
    endcase
  end

  // Broadcast the held request to the cell row
  always_comb begin
    dmask_m      = item_r.domain_mask & DOM_VALID;
    cmd.acquire  = (item_r.opcode == plt_pkg::OP_ACQUIRE) && (dmask_m != '0);
    cmd.retire   = (item_r.opcode == plt_pkg::OP_RELEASE);
    cmd.dmask    = dmask_m;
    cmd.deadline = item_r.deadline_ms;
    cmd.handle   = item_r.handle_in;
    cmd.now      = item_r.now_ms;
  end

  assign link[0] = '0;

  for (genvar s = 0; s < CAPACITY; s++) begin : g_cell
    plt_cell #(
      .SLOT_BITS (SLOT_BITS),
      .IDX       (s)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .commit   (commit),
      .cmd      (cmd),
      .link_in  (link[s]),
      .link_out (link[s+1]),
      .act      (cell_act[s])
    );
  end

  assign acq_ok   = cmd.acquire && link[CAPACITY].found;
  assign rel_ok   = cmd.retire && link[CAPACITY].hit;
  assign inc_mask = acq_ok ? dmask_m : '0;

  plt_holders #(
    .HOLDERS (HOLDERS),
    .CNT_W   (CNT_W)
  ) u_holders (
    .clk      (clk),
    .rst_n    (rst_n),
    .commit   (commit),
    .inc_mask (inc_mask),
    .dec_mask (link[CAPACITY].rel_doms),
    .qdom     (item_r.query_domain),
    .held_nxt (held_nxt),
    .count_nxt(count_nxt)
  );

  // Error code, lease count, result beat and output valid
  always_comb begin
    err = plt_pkg::ERR_NONE;
    case (item_r.opcode)
      plt_pkg::OP_ACQUIRE: begin
        if (dmask_m == '0) begin
          err = plt_pkg::ERR_NO_DOMAINS;
        end else if (!link[CAPACITY].found) begin
          err = plt_pkg::ERR_EXHAUSTED;
        end
      end
      plt_pkg::OP_RELEASE: begin
        if (!link[CAPACITY].hit) err = plt_pkg::ERR_NOT_HELD;
      end
      default: err = plt_pkg::ERR_NONE;
    endcase

    live_nxt = live_r;
    if (acq_ok) begin
      live_nxt = live_r + CNT_W'(1);
    end else if (rel_ok && (live_r != '0)) begin
      live_nxt = live_r - CNT_W'(1);
    end

    out_data_nxt.handle_out        = link[CAPACITY].handle;
    out_data_nxt.error_code        = err;
    out_data_nxt.accepted          = acq_ok || rel_ok;
    out_data_nxt.held_mask         = held_nxt;
    out_data_nxt.overdue_mask      = link[CAPACITY].overdue;
    out_data_nxt.holder_count      = plt_pkg::OUT_CNT_W'(count_nxt);
    out_data_nxt.outstanding_count = plt_pkg::OUT_CNT_W'(live_nxt);

    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      live_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) live_r <= live_nxt;
    end
  end

  // Hold the request through execution; load the result beat on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (in_take) begin
      item_r <= in_data;
    end
    if (commit) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Lease count never exceeds the slot count
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(CAPACITY))
    else $error("lease count above capacity");

  // At most one cell acts on a request
  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_act))
    else $error("more than one slot cell acted");

  // A successful acquire adds exactly one lease
  a_acq_count: assert property (@(posedge clk) disable iff (!rst_n)
    commit && acq_ok |=> live_r == $past(live_r) + CNT_W'(1))
    else $error("acquire did not add one lease");

  // With no live lease nothing is held or overdue
  a_empty_masks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.outstanding_count == '0) && (CAPACITY < 16) |->
      (out_data_r.held_mask == '0) && (out_data_r.overdue_mask == '0))
    else $error("masks set with no live lease");

  // A taken request is held in the execute state with in_stall high
  a_commit_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == plt_pkg::ST_EXEC && !in_stall == 1'b0)
    else $error("request not held for execution");

endmodule
